FILE: hw/rtl/pfi_pkg.sv
`default_nettype none

package pfi_pkg;

   localparam int MAX_FACTOR   = 8;
   localparam int MAX_TAPS     = 16;
   localparam int RESULT_LIMIT = 8;
   localparam int FACTOR_LIMIT = (MAX_FACTOR < RESULT_LIMIT) ? MAX_FACTOR : RESULT_LIMIT;

   localparam int PHASE_W    = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
   localparam int TAP_W      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int COEF_AW    = PHASE_W + TAP_W;
   localparam int COEF_DEPTH = MAX_FACTOR * MAX_TAPS;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int FACTOR_W    = 4;
   localparam int TAPS_W      = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;

   localparam int SAMPLE_W = 16;
   localparam int PROD_W   = 32;
   localparam int ACC_W    = 31;
   localparam int SUM_W    = 33;
   localparam int FRAC_W   = 15;

   localparam logic signed [ACC_W-1:0] ACC_INIT = ACC_W'(1 << 14);
   localparam logic signed [SUM_W-1:0] ACC_MAX  = SUM_W'(64'sh3fffffff);
   localparam logic signed [SUM_W-1:0] ACC_MIN  = SUM_W'(-64'sh40000000);

   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_COEF   = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INTERP_FACTOR  = 1'd0,
      CSR_TAPS_PER_PHASE = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]                  req_type;
      logic signed [SAMPLE_W-1:0]  sample_in;
      logic [2:0]                  coef_phase;
      logic [3:0]                  coef_tap;
      logic signed [SAMPLE_W-1:0]  coef_value;
   } req_data_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic [2:0]                 phase_index;
      logic                       last;
   } rsp_data_type;

   typedef struct packed {
      req_kind_type               kind;
      logic signed [SAMPLE_W-1:0] sample;
      logic [COEF_AW-1:0]         coef_addr;
      logic signed [SAMPLE_W-1:0] coef_value;
   } cmd_type;

   typedef struct packed {
      logic [PHASE_W-1:0] fac_m1;
      logic [TAP_W-1:0]   taps_m1;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic               first_tap;
      logic               last_tap;
      logic [PHASE_W-1:0] phase;
      logic               last_phase;
   } tag_type;

endpackage

`default_nettype wire

FILE: hw/rtl/polyphase_fir_interpolator_unit.sv
`default_nettype none
// Polyphase FIR interpolator, Q15 in and out.
// Request channel (req_valid/req_ready/req_data) carries one transaction per
// sample, coefficient write or history clear; req_type 3 is dropped.
// Each sample produces interp_factor results (0 acts as 1, above 8 as 8) on
// rsp_valid/rsp_ready/rsp_data, phases in order, last set on the final one.
// Coefficient writes and clears produce no result.
// One shared multiply-accumulate handles one tap per cycle while the output
// is not stalled; the back end takes the next command only after the last
// tap of the current sample has been issued.
// A two-entry command queue sits between the request decoder and the MAC
// sequencer; requests keep being taken while the queue has room.
// When rsp_ready is low, the finished result holds in the output register
// and the MAC pipeline freezes at the next phase completion.
// csr_wr_en writes interp_factor (index 0) or taps_per_phase (index 1);
// write only while no transaction is in flight.
// Reset clears the history, the write position and the queue, and sets
// interp_factor to 1 and taps_per_phase to 16. Coefficients are not reset.

module polyphase_fir_interpolator_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire pfi_pkg::req_data_type                req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output pfi_pkg::rsp_data_type                     rsp_data,
   input  wire logic                                 csr_wr_en,
   input  wire logic [pfi_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [pfi_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import pfi_pkg::*;

   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [TAPS_W-1:0]   taps_ff, taps_in;
   cfg_type             cfg;
   logic                cmd_valid;
   logic                cmd_ready;
   cmd_type             cmd;

   always_comb begin
      factor_in = factor_ff;
      taps_in   = taps_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_INTERP_FACTOR:  factor_in = csr_wdata[FACTOR_W-1:0];
            CSR_TAPS_PER_PHASE: taps_in   = csr_wdata[TAPS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_W'(1);
         taps_ff   <= TAPS_W'(16);
      end else begin
         factor_ff <= factor_in;
         taps_ff   <= taps_in;
      end
   end

   always_comb begin
      if (factor_ff == '0) begin
         cfg.fac_m1 = '0;
      end else if (int'(factor_ff) > FACTOR_LIMIT) begin
         cfg.fac_m1 = PHASE_W'(FACTOR_LIMIT - 1);
      end else begin
         cfg.fac_m1 = PHASE_W'(factor_ff - 1'b1);
      end
      if (taps_ff == '0) begin
         cfg.taps_m1 = '0;
      end else if (int'(taps_ff) > MAX_TAPS) begin
         cfg.taps_m1 = TAP_W'(MAX_TAPS - 1);
      end else begin
         cfg.taps_m1 = TAP_W'(taps_ff - 1'b1);
      end
   end

   pfi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   pfi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/pfi_ram.sv
`default_nettype none

module pfi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/pfi_front.sv
`default_nettype none

module pfi_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire pfi_pkg::req_data_type req_data,
   output logic                       cmd_valid,
   input  wire logic                  cmd_ready,
   output pfi_pkg::cmd_type           cmd
);

   import pfi_pkg::*;

   cmd_type             q_ff [QUEUE_DEPTH];
   cmd_type             q_in [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   cmd_type             decoded;
   logic                push;
   logic                pop;

   always_comb begin
      decoded.kind       = REQ_NONE;
      decoded.sample     = req_data.sample_in;
      decoded.coef_addr  = {PHASE_W'(req_data.coef_phase), TAP_W'(req_data.coef_tap)};
      decoded.coef_value = req_data.coef_value;
      case (req_data.req_type)
         REQ_SAMPLE: decoded.kind = REQ_SAMPLE;
         REQ_CLEAR:  decoded.kind = REQ_CLEAR;
         REQ_COEF: begin
            if (int'(req_data.coef_phase) < MAX_FACTOR && int'(req_data.coef_tap) < MAX_TAPS) begin
               decoded.kind = REQ_COEF;
            end
         end
         default:    decoded.kind = REQ_NONE;
      endcase
   end

   assign req_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready && (decoded.kind != REQ_NONE);
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      q_in      = q_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         q_in[wr_ptr_ff] = decoded;
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/pfi_back.sv
`default_nettype none

module pfi_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pfi_pkg::cfg_type      cfg,
   input  wire logic                  cmd_valid,
   output logic                       cmd_ready,
   input  wire pfi_pkg::cmd_type      cmd,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output pfi_pkg::rsp_data_type      rsp_data
);

   import pfi_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type                   state_ff, state_in;
   logic [TAP_W-1:0]            wp_ff, wp_in;
   logic [PHASE_W-1:0]          phase_ff, phase_in;
   logic [TAP_W-1:0]            tap_ff, tap_in;
   logic [TAP_W-1:0]            idx_ff, idx_in;
   logic signed [SAMPLE_W-1:0]  hist_ff [MAX_TAPS];
   logic signed [SAMPLE_W-1:0]  hist_in [MAX_TAPS];
   tag_type                     s1_tag_ff, s1_tag_in;
   logic signed [SAMPLE_W-1:0]  s1_hist_ff, s1_hist_in;
   tag_type                     s2_tag_ff, s2_tag_in;
   logic signed [PROD_W-1:0]    s2_prod_ff, s2_prod_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_data_type                rsp_data_ff, rsp_data_in;

   logic                        take;
   logic                        stall;
   logic                        issue;
   logic                        last_tap;
   logic                        last_phase;
   logic [TAP_W-1:0]            wp_fix;
   logic                        ram_wr_en;
   logic [COEF_AW-1:0]          ram_rd_addr;
   logic [SAMPLE_W-1:0]         ram_rd_data;
   logic signed [SAMPLE_W-1:0]  coef_rd;
   logic signed [PROD_W-1:0]    product;
   logic signed [ACC_W-1:0]     acc_base;
   logic signed [SUM_W-1:0]     sum;
   logic signed [SUM_W-1:0]     sat;

   assign cmd_ready   = (state_ff == ST_IDLE);
   assign take        = cmd_valid && cmd_ready;
   assign stall       = s2_tag_ff.valid && s2_tag_ff.last_tap && rsp_valid_ff && !rsp_ready;
   assign issue       = (state_ff == ST_RUN) && !stall;
   assign last_tap    = (tap_ff == cfg.taps_m1);
   assign last_phase  = (phase_ff == cfg.fac_m1);
   assign wp_fix      = (wp_ff > cfg.taps_m1) ? '0 : wp_ff;
   assign ram_wr_en   = take && (cmd.kind == REQ_COEF);
   assign ram_rd_addr = {phase_ff, tap_ff};

   pfi_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cmd.coef_addr),
      .wr_data (cmd.coef_value),
      .rd_en   (issue),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign coef_rd  = ram_rd_data;
   assign product  = s1_hist_ff * coef_rd;
   assign acc_base = s2_tag_ff.first_tap ? ACC_INIT : acc_ff;
   assign sum      = SUM_W'(acc_base) + SUM_W'(s2_prod_ff);

   always_comb begin
      if (sum > ACC_MAX) begin
         sat = ACC_MAX;
      end else if (sum < ACC_MIN) begin
         sat = ACC_MIN;
      end else begin
         sat = sum;
      end
   end

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      phase_in     = phase_ff;
      tap_in       = tap_ff;
      idx_in       = idx_ff;
      hist_in      = hist_ff;
      s1_tag_in    = s1_tag_ff;
      s1_hist_in   = s1_hist_ff;
      s2_tag_in    = s2_tag_ff;
      s2_prod_in   = s2_prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (take) begin
         case (cmd.kind)
            REQ_SAMPLE: begin
               hist_in[wp_fix] = cmd.sample;
               wp_in           = wp_fix;
               idx_in          = wp_fix;
               phase_in        = '0;
               tap_in          = '0;
               state_in        = ST_RUN;
            end
            REQ_CLEAR: begin
               for (int i = 0; i < MAX_TAPS; i++) begin
                  hist_in[i] = '0;
               end
               wp_in = '0;
            end
            default: begin
            end
         endcase
      end

      if (issue) begin
         s1_tag_in.valid      = 1'b1;
         s1_tag_in.first_tap  = (tap_ff == '0);
         s1_tag_in.last_tap   = last_tap;
         s1_tag_in.phase      = phase_ff;
         s1_tag_in.last_phase = last_phase;
         s1_hist_in           = hist_ff[idx_ff];
         if (last_tap) begin
            tap_in = '0;
            idx_in = wp_ff;
            if (last_phase) begin
               state_in = ST_IDLE;
               wp_in    = (wp_ff == cfg.taps_m1) ? '0 : wp_ff + 1'b1;
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end else begin
            tap_in = tap_ff + 1'b1;
            idx_in = (idx_ff == '0) ? cfg.taps_m1 : idx_ff - 1'b1;
         end
      end else if (!stall) begin
         s1_tag_in.valid = 1'b0;
      end

      if (!stall) begin
         s2_tag_in  = s1_tag_ff;
         s2_prod_in = product;
         if (s2_tag_ff.valid) begin
            acc_in = ACC_W'(sat);
            if (s2_tag_ff.last_tap) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.sample_out  = sat[ACC_W-1:FRAC_W];
               rsp_data_in.phase_index = 3'(s2_tag_ff.phase);
               rsp_data_in.last        = s2_tag_ff.last_phase;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      tap_ff      <= tap_in;
      idx_ff      <= idx_in;
      s1_hist_ff  <= s1_hist_in;
      s2_prod_ff  <= s2_prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      s1_tag_ff.first_tap  <= s1_tag_in.first_tap;
      s1_tag_ff.last_tap   <= s1_tag_in.last_tap;
      s1_tag_ff.phase      <= s1_tag_in.phase;
      s1_tag_ff.last_phase <= s1_tag_in.last_phase;
      s2_tag_ff.first_tap  <= s2_tag_in.first_tap;
      s2_tag_ff.last_tap   <= s2_tag_in.last_tap;
      s2_tag_ff.phase      <= s2_tag_in.phase;
      s2_tag_ff.last_phase <= s2_tag_in.last_phase;
      if (reset) begin
         state_ff        <= ST_IDLE;
         wp_ff           <= '0;
         s1_tag_ff.valid <= 1'b0;
         s2_tag_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < MAX_TAPS; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         wp_ff           <= wp_in;
         s1_tag_ff.valid <= s1_tag_in.valid;
         s2_tag_ff.valid <= s2_tag_in.valid;
         rsp_valid_ff    <= rsp_valid_in;
         hist_ff         <= hist_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (idx_ff <= cfg.taps_m1))
      else $error("history index beyond active taps");

   a_last_on_final_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.last) |-> (rsp_data_ff.phase_index == 3'(cfg.fac_m1)))
      else $error("last flag on wrong phase");

   a_stall_holds_acc: assert property (@(posedge clock) disable iff (reset)
      stall |=> ($stable(acc_ff) && $stable(s2_prod_ff) && $stable(s2_tag_ff)))
      else $error("accumulator moved during output stall");

endmodule

`default_nettype wire

FILE: verif/tb_interp_pkg.sv
`timescale 1ns / 100ps

package tb_interp_pkg;

   import pfi_pkg::*;

   localparam longint SUM_HIGH   = 64'sh3fffffff;
   localparam longint SUM_LOW    = -64'sh40000000;
   localparam longint ROUND_HALF = 64'sd16384;

   class interp_tracker;

      logic signed [SAMPLE_W-1:0] history [MAX_TAPS];
      logic signed [SAMPLE_W-1:0] coef_table [COEF_DEPTH];
      int unsigned                write_pos;
      logic [FACTOR_W-1:0]        factor_reg;
      logic [TAPS_W-1:0]          taps_reg;
      rsp_data_type               expected_outputs [$];
      int unsigned                errors;

      function new();
         foreach (history[i]) history[i] = '0;
         foreach (coef_table[i]) coef_table[i] = '0;
         write_pos  = 0;
         factor_reg = FACTOR_W'(1);
         taps_reg   = TAPS_W'(16);
         errors     = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_INTERP_FACTOR)
            factor_reg = value[FACTOR_W-1:0];
         else
            taps_reg = value[TAPS_W-1:0];
      endfunction

      function int active_factor();
         int f;
         f = factor_reg;
         if (f < 1) f = 1;
         if (f > FACTOR_LIMIT) f = FACTOR_LIMIT;
         return f;
      endfunction

      function int active_taps();
         int t;
         t = taps_reg;
         if (t < 1) t = 1;
         if (t > MAX_TAPS) t = MAX_TAPS;
         return t;
      endfunction

      // accumulate one subfilter over the history, newest sample first
      function logic signed [SAMPLE_W-1:0] filter_phase(int phase, int taps);
         longint acc;
         int     idx;
         int     k;
         acc = ROUND_HALF;
         idx = write_pos;
         for (k = 0; k < taps; k++) begin
            acc += longint'(coef_table[phase * MAX_TAPS + k]) * longint'(history[idx]);
            if (acc > SUM_HIGH)
               acc = SUM_HIGH;
            else if (acc < SUM_LOW)
               acc = SUM_LOW;
            idx = (idx == 0) ? taps - 1 : idx - 1;
         end
         return SAMPLE_W'(acc >>> FRAC_W);
      endfunction

      function void take_request(req_data_type d);
         int           taps;
         int           fac;
         int           p;
         rsp_data_type r;
         case (d.req_type)
            REQ_SAMPLE: begin
               taps = active_taps();
               fac  = active_factor();
               if (write_pos >= taps) write_pos = 0;
               history[write_pos] = d.sample_in;
               for (p = 0; p < fac; p++) begin
                  r.sample_out  = filter_phase(p, taps);
                  r.phase_index = 3'(p);
                  r.last        = (p == fac - 1);
                  expected_outputs.push_back(r);
               end
               write_pos = (write_pos + 1 >= taps) ? 0 : write_pos + 1;
            end
            REQ_COEF: begin
               coef_table[{d.coef_phase, d.coef_tap}] = d.coef_value;
            end
            REQ_CLEAR: begin
               foreach (history[i]) history[i] = '0;
               write_pos = 0;
            end
            default: ;
         endcase
      endfunction

      function void match_output(rsp_data_type got);
         rsp_data_type want;
         if (expected_outputs.size() == 0) begin
            errors++;
            $display("%0t: unexpected output, expected none, actual %0d phase %0d last %0d",
                     $time, got.sample_out, got.phase_index, got.last);
            return;
         end
         want = expected_outputs.pop_front();
         if (got.sample_out !== want.sample_out) begin
            errors++;
            $display("%0t: sample_out mismatch, expected %0d, actual %0d (phase %0d)",
                     $time, want.sample_out, got.sample_out, want.phase_index);
         end
         if (got.phase_index !== want.phase_index) begin
            errors++;
            $display("%0t: phase_index mismatch, expected %0d, actual %0d",
                     $time, want.phase_index, got.phase_index);
         end
         if (got.last !== want.last) begin
            errors++;
            $display("%0t: last mismatch, expected %0d, actual %0d (phase %0d)",
                     $time, want.last, got.last, want.phase_index);
         end
      endfunction

      function int outstanding();
         return expected_outputs.size();
      endfunction

   endclass

endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   import pfi_pkg::*;
   import tb_interp_pkg::*;

   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 48;
   localparam int ITEMS_PER_SET = 8;
   localparam int NUM_SETS      = 12;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   req_data_type                 req_data = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   rsp_data_type                 rsp_data;
   logic                         csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;

   bit                           steady = 1'b0;
   int                           quiet_cycles = 0;
   interp_tracker                tracker = new();

   polyphase_fir_interpolator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.match_output(rsp_data);
      rsp_ready <= steady || ($urandom_range(99) >= 33);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] pick_q15();
      case ($urandom_range(7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         3: return -16'sd1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic req_data_type noise_fields();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return req_data_type'(raw[$bits(req_data_type)-1:0]);
   endfunction

   function automatic req_data_type sample_item(logic signed [SAMPLE_W-1:0] value);
      req_data_type d;
      d           = noise_fields();
      d.req_type  = REQ_SAMPLE;
      d.sample_in = value;
      return d;
   endfunction

   function automatic req_data_type coef_item(int phase, int tap,
                                              logic signed [SAMPLE_W-1:0] value);
      req_data_type d;
      d            = noise_fields();
      d.req_type   = REQ_COEF;
      d.coef_phase = 3'(phase);
      d.coef_tap   = 4'(tap);
      d.coef_value = value;
      return d;
   endfunction

   function automatic req_data_type kind_item(req_kind_type kind);
      req_data_type d;
      d          = noise_fields();
      d.req_type = kind;
      return d;
   endfunction

   function automatic req_data_type random_item();
      int roll;
      roll = $urandom_range(99);
      if (roll < 72)
         return sample_item(pick_q15());
      else if (roll < 87)
         return coef_item($urandom_range(7), $urandom_range(15), pick_q15());
      else if (roll < 94)
         return kind_item(REQ_CLEAR);
      else
         return kind_item(REQ_NONE);
   endfunction

   task automatic send_request(req_data_type d);
      if (!steady) begin
         while ($urandom_range(99) < 33) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (!req_ready);
      tracker.take_request(d);
   endtask

   task automatic set_rates(logic [CSR_DATA_W-1:0] factor, logic [CSR_DATA_W-1:0] taps);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_INTERP_FACTOR;
      csr_wdata <= factor;
      @(posedge clock);
      tracker.write_register(CSR_INTERP_FACTOR, factor);
      csr_index <= CSR_TAPS_PER_PHASE;
      csr_wdata <= taps;
      @(posedge clock);
      tracker.write_register(CSR_TAPS_PER_PHASE, taps);
      csr_wr_en <= 1'b0;
   endtask

   // hold until every output has arrived and the back end has settled
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] factor_set [8];
      logic [CSR_DATA_W-1:0] taps_set [8];
      req_data_type          d;
      int                    counted;
      int                    s;
      int                    a;

      factor_set = '{5'd8, 5'd1, 5'd0, 5'd15, 5'd4, 5'd9, 5'd2, 5'd31};
      taps_set   = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd9, 5'd17, 5'd16, 5'd1};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      set_rates(5'd8, 5'd16);

      // load the whole table so no unwritten coefficient is ever read
      for (a = 0; a < COEF_DEPTH; a++) begin
         if (a / MAX_TAPS == 0)
            send_request(coef_item(0, a % MAX_TAPS, 16'sh8000));
         else if (a / MAX_TAPS == 1)
            send_request(coef_item(1, a % MAX_TAPS, 16'sh7fff));
         else
            send_request(coef_item(a / MAX_TAPS, a % MAX_TAPS, pick_q15()));
      end

      // drive both saturation limits, then clear and restart
      repeat (16) send_request(sample_item(16'sh8000));
      send_request(sample_item(16'sh7fff));
      send_request(sample_item('0));
      send_request(coef_item(2, 0, 16'sh7fff));
      send_request(kind_item(REQ_NONE));
      send_request(kind_item(REQ_CLEAR));
      send_request(sample_item(16'sh7fff));
      send_request(sample_item(16'sh8000));
      drain();

      for (s = 0; s < NUM_SETS; s++) begin
         if (s < 8)
            set_rates(factor_set[s], taps_set[s]);
         else
            set_rates(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
         steady  = (s == 2);
         counted = 0;
         while (counted < ITEMS_PER_SET) begin
            d = random_item();
            send_request(d);
            if (d.req_type != REQ_NONE) counted++;
         end
         drain();
         steady = 1'b0;
      end

      if (tracker.errors == 0 && tracker.outstanding() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/pfi_pkg.sv
hw/rtl/pfi_ram.sv
hw/rtl/pfi_front.sv
hw/rtl/pfi_back.sv
hw/rtl/polyphase_fir_interpolator_unit.sv
verif/tb_interp_pkg.sv
verif/tb_top.sv
